/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the escape sequence decoder: character
// codes and the format of one decoded group of code units.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int MaxUnits   = 6;
   localparam int UnitWidth  = 16;
   localparam int CountWidth = $clog2(MaxUnits + 1);
   localparam int IndexWidth = $clog2(MaxUnits);

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharU         = 8'h75;
   localparam logic [7:0] CharT         = 8'h74;
   localparam logic [7:0] CharB         = 8'h62;
   localparam logic [7:0] CharN         = 8'h6E;
   localparam logic [7:0] CharR         = 8'h72;
   localparam logic [7:0] CharF         = 8'h66;
   localparam logic [7:0] CharQuote     = 8'h27;
   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharBspace    = 8'h08;
   localparam logic [7:0] CharNewline   = 8'h0A;
   localparam logic [7:0] CharReturn    = 8'h0D;
   localparam logic [7:0] CharFeed      = 8'h0C;

   // one group of code units produced by a single input item
   typedef struct packed {
      logic [MaxUnits-1:0][UnitWidth-1:0] units;
      logic [CountWidth-1:0]              count;
      logic                               last;
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type group;
   } push_type;

endpackage

/* rtl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Escape state machine: takes one byte per item, tracks the pending escape
// and turns each byte into a group of zero to six code units.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_byte,
   input  logic            end_of_string,
   output jsu_pkg::push_type push
);
   import jsu_pkg::*;

   typedef enum logic [4:0] {
      PH_PLAIN     = 5'b00001,
      PH_ESC       = 5'b00010,
      PH_OCT_LONG  = 5'b00100,
      PH_OCT_SHORT = 5'b01000,
      PH_HEX       = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  oval_ff, oval_in;
   logic [1:0]  ocnt_ff, ocnt_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [15:0] hval_ff, hval_in;
   logic [2:0][7:0] held_ff, held_in;

   logic [MaxUnits-1:0][UnitWidth-1:0] units;
   logic [CountWidth-1:0] n;
   logic        do_plain;
   logic        is_oct;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [1:0]  ocnt_inc;
   logic [7:0]  oval_shift;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hex_val = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_oct     = (in_byte[7:3] == 5'b00110);
   assign ocnt_inc   = ocnt_ff + 2'd1;
   assign oval_shift = {oval_ff[4:0], in_byte[2:0]};

   always_comb begin
      phase_in = phase_ff;
      oval_in  = oval_ff;
      ocnt_in  = ocnt_ff;
      hcnt_in  = hcnt_ff;
      hval_in  = hval_ff;
      held_in  = held_ff;
      units    = '0;
      n        = '0;
      do_plain = 1'b0;

      unique case (phase_ff)
         PH_ESC: begin
            phase_in = PH_PLAIN;
            if (in_byte == CharT) begin
               units[n] = {8'h00, CharTab};     n = n + 1'b1;
            end else if (in_byte == CharB) begin
               units[n] = {8'h00, CharBspace};  n = n + 1'b1;
            end else if (in_byte == CharN) begin
               units[n] = {8'h00, CharNewline}; n = n + 1'b1;
            end else if (in_byte == CharR) begin
               units[n] = {8'h00, CharReturn};  n = n + 1'b1;
            end else if (in_byte == CharF) begin
               units[n] = {8'h00, CharFeed};    n = n + 1'b1;
            end else if (in_byte == CharQuote || in_byte == CharDquote ||
                         in_byte == CharBackslash) begin
               units[n] = {8'h00, in_byte};     n = n + 1'b1;
            end else if (in_byte == CharU) begin
               phase_in = PH_HEX;
               hcnt_in  = 2'd0;
               hval_in  = 16'd0;
            end else if (is_oct) begin
               oval_in  = {5'd0, in_byte[2:0]};
               ocnt_in  = 2'd1;
               phase_in = in_byte[2] ? PH_OCT_SHORT : PH_OCT_LONG;
            end else begin
               units[n] = {8'h00, CharBackslash}; n = n + 1'b1;
               do_plain = 1'b1;
            end
         end
         PH_OCT_LONG, PH_OCT_SHORT: begin
            if (is_oct) begin
               oval_in = oval_shift;
               ocnt_in = ocnt_inc;
               if ((phase_ff == PH_OCT_LONG && ocnt_inc == 2'd3) ||
                   (phase_ff == PH_OCT_SHORT && ocnt_inc >= 2'd2)) begin
                  units[n] = {8'h00, oval_shift}; n = n + 1'b1;
                  phase_in = PH_PLAIN;
                  ocnt_in  = 2'd0;
               end
            end else begin
               units[n] = {8'h00, oval_ff}; n = n + 1'b1;
               phase_in = PH_PLAIN;
               ocnt_in  = 2'd0;
               do_plain = 1'b1;
            end
         end
         PH_HEX: begin
            if (hex_ok) begin
               hval_in = {hval_ff[11:0], hex_val};
               if (hcnt_ff == 2'd3) begin
                  units[n] = {hval_ff[11:0], hex_val}; n = n + 1'b1;
                  phase_in = PH_PLAIN;
                  hcnt_in  = 2'd0;
               end else begin
                  held_in[hcnt_ff] = in_byte;
                  hcnt_in          = hcnt_ff + 2'd1;
               end
            end else begin
               // short \u: give back what was held
               units[n] = {8'h00, CharBackslash}; n = n + 1'b1;
               units[n] = {8'h00, CharU};         n = n + 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (i < 32'(hcnt_ff)) begin
                     units[n] = {8'h00, held_ff[i]}; n = n + 1'b1;
                  end
               end
               phase_in = PH_PLAIN;
               hcnt_in  = 2'd0;
               do_plain = 1'b1;
            end
         end
         default: begin
            phase_in = PH_PLAIN;
            do_plain = 1'b1;
         end
      endcase

      if (do_plain) begin
         if (in_byte == CharBackslash) begin
            phase_in = PH_ESC;
         end else begin
            units[n] = {8'h00, in_byte}; n = n + 1'b1;
         end
      end

      if (end_of_string) begin
         unique case (phase_in)
            PH_ESC: begin
               units[n] = {8'h00, CharBackslash}; n = n + 1'b1;
            end
            PH_OCT_LONG, PH_OCT_SHORT: begin
               units[n] = {8'h00, oval_in}; n = n + 1'b1;
            end
            PH_HEX: begin
               units[n] = {8'h00, CharBackslash}; n = n + 1'b1;
               units[n] = {8'h00, CharU};         n = n + 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (i < 32'(hcnt_in)) begin
                     units[n] = {8'h00, held_in[i]}; n = n + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         phase_in = PH_PLAIN;
         ocnt_in  = 2'd0;
         hcnt_in  = 2'd0;
      end
   end

   assign push.valid       = accept && (n != '0);
   assign push.group.units = units;
   assign push.group.count = n;
   assign push.group.last  = end_of_string;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         ocnt_ff  <= 2'd0;
         hcnt_ff  <= 2'd0;
         oval_ff  <= 8'd0;
         hval_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ocnt_ff  <= ocnt_in;
         hcnt_ff  <= hcnt_in;
         oval_ff  <= oval_in;
         hval_ff  <= hval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

/* rtl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry queue of unit groups between the escape front and the emitter.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output jsu_pkg::group_type head
);
   import jsu_pkg::*;

   group_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push.valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.group;
      end
   end

endmodule

/* rtl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Unit emitter: while the output is not stalled, walks the head group one code unit per
// cycle into a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  jsu_pkg::group_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_code_unit,
   output logic               rsp_last_unit
);
   import jsu_pkg::*;

   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [15:0]           unit_ff;
   logic                  last_ff;
   logic                  load;
   logic                  at_end;

   assign load   = !valid_ff || !rsp_stall;
   assign at_end = (CountWidth'(idx_ff) == head.count - 1'b1);
   assign pop    = load && head_valid && at_end;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            idx_in = at_end ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         unit_ff <= head.units[idx_ff];
         last_ff <= head.last && at_end;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_unit = unit_ff;
   assign rsp_last_unit = last_ff;

endmodule

/* rtl/java_string_unescape.sv */
// Path: an accepted byte's code units enter the group queue, then the output register.
// Throughput: one byte per cycle while each byte gives at most one code unit and the
// output is not stalled; a byte that gives k units holds the output emitter until all k
// are sent; the two-entry queue stalls input when full. Unit-less bytes are not queued.
// Reset: synchronous; clears the escape phase, digit counters, queue and output valid.
// ----------------------------------------------------------------------------
// java_string_unescape
// Streaming decoder for Java escape sequences: bytes in, UTF-16 code units out.
// ----------------------------------------------------------------------------
module java_string_unescape (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_unit
);
   import jsu_pkg::*;

   push_type  push;
   group_type head;
   logic      head_valid;
   logic      full;
   logic      pop;
   logic      accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .push          (push)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   jsu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_last_unit (rsp_last_unit)
   );

endmodule

/* sim/jsu_checker.sv */
// ----------------------------------------------------------------------------
// jsu_checker
// Watches both channels of the escape sequence decoder. Every accepted byte
// runs through an independent decoder model that queues the code units it
// should produce; every accepted code unit is compared against the oldest
// queued one. Mismatches and unexpected units are reported and counted.
// ----------------------------------------------------------------------------
module jsu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_code_unit,
   input  logic        rsp_last_unit,
   output int          fail_count,
   output int          units_outstanding,
   output int          units_checked
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PLAIN,
      AFTER_BSL,
      OCT_LONG,
      OCT_SHORT,
      IN_HEX
   } esc_phase_type;

   typedef struct packed {
      logic [15:0] unit;
      logic        last;
   } unit_exp_type;

   unit_exp_type  pending_units[$];

   esc_phase_type esc_phase;
   logic [7:0] oct_val;
   logic [1:0] oct_cnt;
   logic [7:0] hex_held[3];
   logic [1:0] hex_cnt;
   logic [15:0] hex_val;
   int         step_units;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch @%0t: %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic add_unit(input logic [15:0] u);
      unit_exp_type entry;
      if (step_units < MaxUnits) begin
         entry.unit = u;
         entry.last = 1'b0;
         pending_units.insert(pending_units.size(), entry);
         step_units++;
      end
   endtask

   task automatic take_plain(input logic [7:0] c);
      if (c == CharBackslash) esc_phase = AFTER_BSL;
      else add_unit({8'h00, c});
   endtask

   // abandoned \u: backslash, 'u', then the digits held so far
   task automatic flush_hex();
      add_unit({8'h00, CharBackslash});
      add_unit({8'h00, CharU});
      for (int i = 0; i < hex_cnt; i++) add_unit({8'h00, hex_held[i]});
   endtask

   task automatic decode_byte(input logic [7:0] c);
      int   digit;
      logic is_octal;
      digit = -1;
      if (c >= "0" && c <= "9") digit = c - "0";
      else if (c >= "a" && c <= "f") digit = c - "a" + 10;
      else if (c >= "A" && c <= "F") digit = c - "A" + 10;
      is_octal = (c >= "0" && c <= "7");
      case (esc_phase)
         AFTER_BSL: begin
            esc_phase = PLAIN;
            case (c)
               CharT:         add_unit({8'h00, CharTab});
               CharB:         add_unit({8'h00, CharBspace});
               CharN:         add_unit({8'h00, CharNewline});
               CharR:         add_unit({8'h00, CharReturn});
               CharF:         add_unit({8'h00, CharFeed});
               CharQuote:     add_unit({8'h00, CharQuote});
               CharDquote:    add_unit({8'h00, CharDquote});
               CharBackslash: add_unit({8'h00, CharBackslash});
               CharU: begin
                  esc_phase = IN_HEX;
                  hex_cnt = 0;
                  hex_val = 0;
               end
               default: begin
                  if (is_octal) begin
                     oct_val = c - "0";
                     oct_cnt = 1;
                     // 0-3 may take three digits, 4-7 only two
                     if (c <= "3") esc_phase = OCT_LONG;
                     else esc_phase = OCT_SHORT;
                  end else begin
                     add_unit({8'h00, CharBackslash});
                     take_plain(c);
                  end
               end
            endcase
         end
         OCT_LONG, OCT_SHORT: begin
            if (is_octal) begin
               oct_val = (oct_val << 3) + (c - "0");
               oct_cnt = oct_cnt + 2'd1;
               if (oct_cnt >= ((esc_phase == OCT_LONG) ? 2'd3 : 2'd2)) begin
                  add_unit({8'h00, oct_val});
                  esc_phase = PLAIN;
                  oct_cnt = 0;
               end
            end else begin
               add_unit({8'h00, oct_val});
               esc_phase = PLAIN;
               oct_cnt = 0;
               take_plain(c);
            end
         end
         IN_HEX: begin
            if (digit >= 0) begin
               hex_val = {hex_val[11:0], digit[3:0]};
               if (hex_cnt >= 2'd3) begin
                  add_unit(hex_val);
                  esc_phase = PLAIN;
                  hex_cnt = 0;
               end else begin
                  hex_held[hex_cnt] = c;
                  hex_cnt = hex_cnt + 2'd1;
               end
            end else begin
               flush_hex();
               esc_phase = PLAIN;
               hex_cnt = 0;
               take_plain(c);
            end
         end
         default: begin
            esc_phase = PLAIN;
            take_plain(c);
         end
      endcase
   endtask

   task automatic predict_units(input logic [7:0] c, input logic eos);
      step_units = 0;
      decode_byte(c);
      if (eos) begin
         if (esc_phase == AFTER_BSL) add_unit({8'h00, CharBackslash});
         else if (esc_phase == OCT_LONG || esc_phase == OCT_SHORT) add_unit({8'h00, oct_val});
         else if (esc_phase == IN_HEX) flush_hex();
         esc_phase = PLAIN;
         oct_cnt = 0;
         hex_cnt = 0;
         if (step_units > 0) pending_units[pending_units.size() - 1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin : monitor
      unit_exp_type want;
      if (reset) begin
         esc_phase = PLAIN;
         oct_val = 0;
         oct_cnt = 0;
         hex_cnt = 0;
         hex_val = 0;
         pending_units.delete();
         fail_count = 0;
         units_checked = 0;
      end else begin
         if (req_valid && !req_stall) predict_units(req_in_byte, req_end_of_string);
         if (rsp_valid && !rsp_stall) begin
            if (pending_units.size() == 0) begin
               report_mismatch("code unit with nothing pending", rsp_code_unit, 'x);
            end else begin
               want = pending_units.pop_front();
               if (rsp_code_unit !== want.unit)
                  report_mismatch("code_unit", rsp_code_unit, want.unit);
               if (rsp_last_unit !== want.last)
                  report_mismatch("last_unit", {15'd0, rsp_last_unit}, {15'd0, want.last});
               units_checked++;
            end
         end
      end
      units_outstanding = pending_units.size();
   end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for java_string_unescape. Sends a directed set of escape edge
// cases, then random strings built from plain bytes, simple, octal and \u
// escapes, broken escapes and raw noise, under bursty input and a varying
// output stall pattern. Checking is done by jsu_checker.
// ----------------------------------------------------------------------------
module tb;
   import jsu_pkg::*;

   localparam int RandomItems = 280;
   localparam int HoldCycles  = 60;
   localparam int LimitCycles = 400000;

   typedef enum {FLOW, LIGHT, PULSED, HEAVY} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_end_of_string;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_code_unit;
   logic        rsp_last_unit;

   int check_failures;
   int units_outstanding;
   int units_checked;

   int   bytes_sent;
   int   strings_sent;
   int   hold_requests;
   int   burst_left;
   logic gaps_on;
   logic [7:0] text_q[$];

   string esc_letters = "tbnrf'\"\\";
   string hex_chars   = "0123456789abcdefABCDEF";

   java_string_unescape DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_last_unit     (rsp_last_unit)
   );

   jsu_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_last_unit     (rsp_last_unit),
      .fail_count        (check_failures),
      .units_outstanding (units_outstanding),
      .units_checked     (units_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * LimitCycles);
      $display("timeout with %0d code units outstanding", units_outstanding);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: stall pattern changes mode every so often, plus a long hold on request
   initial begin : receiver
      rx_mode_type mode;
      int       mode_left;
      int       hold_left;
      int       holds_done;
      int       tick;
      rsp_stall = 1'b0;
      mode = FLOW;
      mode_left = 0;
      hold_left = 0;
      holds_done = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_requests > holds_done) begin
            holds_done++;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               FLOW:    rsp_stall <= 1'b0;
               LIGHT:   rsp_stall <= ($urandom_range(0, 99) < 30);
               PULSED:  rsp_stall <= tick[2];
               default: rsp_stall <= ($urandom_range(0, 99) < 75);
            endcase
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic eos);
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic offer(input logic [7:0] b, input logic eos);
      int gap;
      if (gaps_on && burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      send_item(b, eos);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s.getc(i), i == s.len() - 1);
      strings_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (units_outstanding != 0) @(negedge clock);
   endtask

   task automatic add_byte(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   // one random piece of an escaped string, mostly well formed
   task automatic add_token();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         add_byte(8'($urandom_range(32, 126)));
      end else if (pick < 33) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 48) begin
         add_byte(CharBackslash);
         add_byte(esc_letters.getc($urandom_range(0, 7)));
      end else if (pick < 63) begin
         // up to four digits so the length limits get crossed
         add_byte(CharBackslash);
         n = $urandom_range(1, 4);
         repeat (n) add_byte(8'(8'h30 + $urandom_range(0, 7)));
      end else if (pick < 78) begin
         add_byte(CharBackslash);
         add_byte(CharU);
         repeat (4) add_byte(hex_chars.getc($urandom_range(0, 21)));
      end else if (pick < 88) begin
         add_byte(CharBackslash);
         add_byte(CharU);
         n = $urandom_range(0, 3);
         repeat (n) add_byte(hex_chars.getc($urandom_range(0, 21)));
      end else if (pick < 96) begin
         add_byte(CharBackslash);
         add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_byte(CharBackslash);
      end
   endtask

   initial begin : stimulus
      int random_bytes;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_end_of_string = 1'b0;
      bytes_sent = 0;
      strings_sent = 0;
      hold_requests = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      random_bytes = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full \u, max octal, unknown escape on 0xff, zero byte,
      // short \u, end-of-string flushes and an octal cut short
      send_text("\\u00E9");
      send_text("\\377");
      send_item(CharBackslash, 1'b0);
      send_item(8'hFF, 1'b1);
      strings_sent++;
      send_item(8'h00, 1'b1);
      strings_sent++;
      send_text("\\u1g");
      send_text("\\");
      send_text("\\7x");
      send_text("\\5");
      send_text("\\uAb");

      while (random_bytes < RandomItems) begin
         text_q.delete();
         n = $urandom_range(1, 6);
         repeat (n) add_token();
         if (strings_sent == 12) hold_requests++;
         if (strings_sent % 20 == 19) wait_drained();
         gaps_on = (strings_sent % 9) < 6;
         foreach (text_q[i]) offer(text_q[i], i == text_q.size() - 1);
         random_bytes += text_q.size();
         strings_sent++;
      end

      wait_drained();
      repeat (12) @(posedge clock);
      $display("covered %0d bytes in %0d strings, %0d code units checked",
               bytes_sent, strings_sent, units_checked);
      $display("included escape edge cases, random escape mixes, a %0d-cycle output hold",
               HoldCycles);
      if (check_failures == 0 && units_outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* java_string_unescape.f */
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/java_string_unescape.sv
sim/jsu_checker.sv
sim/tb.sv
